/* design/lkvt_pkg.sv */
package lkvt_pkg;

  localparam logic [2:0] CMD_SET     = 3'd0;
  localparam logic [2:0] CMD_GET     = 3'd1;
  localparam logic [2:0] CMD_GET_INS = 3'd2;
  localparam logic [2:0] CMD_DELETE  = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] lookup_key;
    logic [31:0] new_value;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] read_value;
    logic [7:0]  entry_count;
    logic        full_error;
  } out_t;

  typedef struct packed {
    logic load_req;
    logic rd_idx;
    logic rd_next;
    logic idx_inc;
    logic set_found;
    logic exec;
    logic shift_wr;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic       scan_needed;
    logic       key_match;
    logic       scan_last;
    logic       del_shift;
    logic       shift_more;
    logic       out_free;
  } sts_t;

endpackage

/* design/lkvt_ctrl.sv */
module lkvt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lkvt_pkg::sts_t sts,
  output lkvt_pkg::ctl_t ctl
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_READ     = 3'd1;
  localparam logic [2:0] ST_CMP      = 3'd2;
  localparam logic [2:0] ST_EXEC     = 3'd3;
  localparam logic [2:0] ST_SHIFT_RD = 3'd4;
  localparam logic [2:0] ST_SHIFT_WR = 3'd5;
  localparam logic [2:0] ST_RESP     = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load_req = 1'b1;
          state_nxt    = sts.scan_needed ? ST_READ : ST_EXEC;
        end
      end
      ST_READ: begin
        ctl.rd_idx = 1'b1;
        state_nxt  = ST_CMP;
      end
      ST_CMP: begin
        if (sts.key_match) begin
          ctl.set_found = 1'b1;
          state_nxt     = ST_EXEC;
        end else if (sts.scan_last) begin
          state_nxt = ST_EXEC;
        end else begin
          ctl.idx_inc = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = sts.del_shift ? ST_SHIFT_RD : ST_RESP;
      end
      ST_SHIFT_RD: begin
        ctl.rd_next = 1'b1;
        state_nxt   = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        ctl.shift_wr = 1'b1;
        ctl.idx_inc  = 1'b1;
        state_nxt    = sts.shift_more ? ST_SHIFT_RD : ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/lkvt_dpath.sv */
module lkvt_dpath #(
  parameter int CAPACITY   = 128,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lkvt_pkg::in_t  in_data,
  input  lkvt_pkg::ctl_t ctl,
  output lkvt_pkg::sts_t sts,
  input  logic           out_ready,
  output logic           out_valid,
  output lkvt_pkg::out_t out_data
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = KEY_BITS + VALUE_BITS;

  logic [EW-1:0] entry_mem [CAPACITY];
  logic [EW-1:0] rdata_r;

  logic [2:0]            cmd_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [IW-1:0]         idx_r;
  logic [CW-1:0]         used_r;
  logic                  found_r;
  logic                  full_r;
  logic [31:0]           rd_r;
  logic                  out_valid_r;
  lkvt_pkg::out_t        out_r;

  logic [KEY_BITS+31:0]   key_ext;
  logic [VALUE_BITS+31:0] val_ext;
  logic [VALUE_BITS+31:0] rval_ext;
  logic [VALUE_BITS+31:0] wval_ext;
  logic [CW+7:0]          cnt_ext;
  logic [IW-1:0]          rd_addr;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [EW-1:0]          wr_data;
  logic                   room;
  logic [CW-1:0]          idx_w;

  assign key_ext  = {{KEY_BITS{1'b0}}, in_data.lookup_key};
  assign val_ext  = {{VALUE_BITS{1'b0}}, in_data.new_value};
  assign rval_ext = {32'b0, rdata_r[VALUE_BITS-1:0]};
  assign wval_ext = {32'b0, val_r};
  assign cnt_ext  = {8'b0, used_r};
  assign room     = (used_r < CW'(CAPACITY));
  assign idx_w    = CW'(idx_r);
  assign rd_addr  = ctl.rd_next ? (idx_r + IW'(1)) : idx_r;

  assign sts.scan_needed = (in_data.cmd <= lkvt_pkg::CMD_DELETE) && (used_r != '0);
  assign sts.key_match   = (rdata_r[EW-1:VALUE_BITS] == key_r);
  assign sts.scan_last   = ((idx_w + CW'(1)) == used_r);
  assign sts.del_shift   = (cmd_r == lkvt_pkg::CMD_DELETE) && found_r &&
                           ((idx_w + CW'(1)) < used_r);
  assign sts.shift_more  = ((idx_w + CW'(1)) < used_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = {key_r, val_r};
    if (ctl.shift_wr) begin
      wr_en   = 1'b1;
      wr_data = rdata_r;
    end else if (ctl.exec) begin
      case (cmd_r)
        lkvt_pkg::CMD_SET: begin
          if (found_r) begin
            wr_en = 1'b1;
          end else if (room) begin
            wr_en   = 1'b1;
            wr_addr = used_r[IW-1:0];
          end
        end
        lkvt_pkg::CMD_GET_INS: begin
          if (!found_r && room) begin
            wr_en   = 1'b1;
            wr_addr = used_r[IW-1:0];
            wr_data = {key_r, {VALUE_BITS{1'b0}}};
          end
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_idx || ctl.rd_next) begin
      rdata_r <= entry_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      cmd_r <= in_data.cmd;
      key_r <= key_ext[KEY_BITS-1:0];
      val_r <= val_ext[VALUE_BITS-1:0];
    end
    if (ctl.load_req) begin
      idx_r <= '0;
    end else if (ctl.idx_inc) begin
      idx_r <= idx_r + IW'(1);
    end
    if (ctl.load_req) begin
      found_r <= 1'b0;
    end else if (ctl.set_found) begin
      found_r <= 1'b1;
    end
    if (ctl.exec) begin
      full_r <= 1'b0;
      rd_r   <= '0;
      case (cmd_r)
        lkvt_pkg::CMD_SET: begin
          if (found_r || room) begin
            rd_r <= wval_ext[31:0];
          end else begin
            full_r <= 1'b1;
          end
        end
        lkvt_pkg::CMD_GET: begin
          if (found_r) begin
            rd_r <= rval_ext[31:0];
          end
        end
        lkvt_pkg::CMD_GET_INS: begin
          if (found_r) begin
            rd_r <= rval_ext[31:0];
          end else if (!room) begin
            full_r <= 1'b1;
          end
        end
        default: rd_r <= '0;
      endcase
    end
    if (ctl.load_out) begin
      out_r.found       <= found_r;
      out_r.read_value  <= rd_r;
      out_r.entry_count <= cnt_ext[7:0];
      out_r.full_error  <= full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.exec) begin
        case (cmd_r) inside
          lkvt_pkg::CMD_SET, lkvt_pkg::CMD_GET_INS: begin
            if (!found_r && room) begin
              used_r <= used_r + CW'(1);
            end
          end
          lkvt_pkg::CMD_DELETE: begin
            if (found_r) begin
              used_r <= used_r - CW'(1);
            end
          end
          lkvt_pkg::CMD_CLEAR: used_r <= '0;
          default: used_r <= used_r;
        endcase
      end
      if (ctl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* design/linear_key_value_table.sv */
// Key-value table with entries packed in insertion order.
// A request enters on in_valid/in_ready with in_data carrying cmd, lookup_key
// and new_value; exactly one result leaves on out_valid/out_ready in out_data.
// The entries live in a single-port-write, registered-read memory that the
// controller walks one entry at a time.
// Each entry examined is read in ST_READ and compared in ST_CMP; the walk
// stops at a hit or after the last entry, and ST_EXEC and ST_RESP follow.
// A delete then moves the later entries down by one, reading and writing each
// in turn. Clear, unused codes and lookups in an empty table skip the walk.
// One request is in work at a time and in_ready returns in the cycle after the
// result is loaded, so a new request is accepted only once the last is done.
// The result sits in an output register; a new request can be accepted while
// it waits, but the next result is held back until the receiver takes the
// previous one, and the block then stalls with in_ready low.
// Reset empties the table at once by zeroing the entry count; no clearing
// pass runs and the first request can be accepted right after reset.
module linear_key_value_table #(
  parameter int CAPACITY   = 128,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lkvt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lkvt_pkg::out_t out_data
);

  lkvt_pkg::ctl_t ctl;
  lkvt_pkg::sts_t sts;

  lkvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  lkvt_dpath #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
